/* rtl/pcfd_pkg.sv */
package pcfd_pkg;

  // signed Q8.16 word
  localparam int QW = 24;
  localparam logic signed [QW-1:0] Q_MAX = 24'sh7FFFFF;
  localparam logic signed [QW-1:0] Q_MIN = -24'sh800000;

  // output scaling and measurement normalisation
  localparam logic [7:0]         OUT_SCALE       = 8'd255;
  localparam logic [7:0]         OUT_OFFSET      = 8'd0;
  localparam logic [15:0]        MEAS_FULL_SCALE = 16'd65535;
  localparam logic signed [18:0] OUT_FLOOR       = 19'sd0;

  // serial multiplier: a is the shifted operand, b is consumed one bit a cycle
  localparam int MUL_A_W   = 50;
  localparam int MUL_B_W   = 25;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // serial restoring divider
  localparam int DIV_N_W   = 44;
  localparam int DIV_D_W   = 18;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_FILTER_TIME   = 3'd3,
    REG_SAMPLE_PERIOD = 3'd4,
    REG_INTEG_UPPER   = 3'd5,
    REG_INTEG_LOWER   = 3'd6,
    REG_OUT_UPPER     = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_ERR,
    ST_DIV_NORM,
    ST_MUL_P,
    ST_MUL_I1,
    ST_MUL_I2,
    ST_MUL_D,
    ST_MUL_F,
    ST_PREP_F,
    ST_DIV_F,
    ST_FINISH,
    ST_EMIT
  } pcfd_state_e;

  function automatic logic signed [QW-1:0] sat24(input logic signed [63:0] v);
    logic signed [QW-1:0] r;
    if (v > 64'(Q_MAX)) r = Q_MAX;
    else if (v < 64'(Q_MIN)) r = Q_MIN;
    else r = v[QW-1:0];
    return r;
  endfunction

  // upper bound tested first, then lower
  function automatic logic signed [63:0] clamp2(input logic signed [63:0] v,
                                                input logic signed [63:0] hi,
                                                input logic signed [63:0] lo);
    logic signed [63:0] r;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    else r = v;
    return r;
  endfunction

endpackage

/* rtl/pcfd_mul.sv */
module pcfd_mul import pcfd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic                      done_o,
  output logic signed [MUL_P_W-1:0] prod_o
);

  logic signed [MUL_P_W-1:0] a_q, a_d, acc_q, acc_d, addend;
  logic [MUL_B_W-1:0]        b_q, b_d;
  logic [MUL_CNT_W-1:0]      cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic                      last;

  assign last   = (cnt_q == MUL_CNT_W'(MUL_B_W - 1));
  assign addend = b_q[0] ? a_q : '0;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = MUL_P_W'(a_i);
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // top bit of b carries negative weight
      acc_d = last ? (acc_q - addend) : (acc_q + addend);
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/pcfd_div.sv */
module pcfd_div import pcfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] num_i,
  input  logic [DIV_D_W-1:0] den_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quo_o
);

  logic [DIV_N_W-1:0]   q_q, q_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d, den_q, den_d;
  logic [DIV_D_W:0]     trial;
  logic                 fits;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic                 last;

  assign last  = (cnt_q == DIV_CNT_W'(DIV_N_W - 1));
  assign trial = {rem_q, q_q[DIV_N_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    q_d    = q_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      q_d    = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit a cycle, remainder stays below the divisor
      rem_d = fits ? DIV_D_W'(trial - {1'b0, den_q}) : trial[DIV_D_W-1:0];
      q_d   = {q_q[DIV_N_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

/* rtl/pid_controller_filtered_derivative.sv */
// channel   dir  signals                  contents (lowest bit first)
// s_axis    in   tvalid tready tdata[47:0] measurement, set_point, tick_elapsed
// m_axis    out  tvalid tready tdata[7:0]  drive_code
//                tuser[1:0]                updated, bad_set_point
// cfg       in   we idx[2:0] data[23:0]    register write, no read-back
//
// an update runs three division steps and five multiply steps on one bit-serial divider
// and one bit-serial multiplier, plus the check, prepare, finish and emit steps; the
// filter division is skipped when 2tau + Ts is zero
// an item with the gate closed or a zero set point goes from check straight to emit
// one item in flight; input ready only in idle
// the result sits in an output register until taken; a stalled output holds the
// sequencer in its last step
// reset clears the controller state and loads the register defaults
module pid_controller_filtered_derivative import pcfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // measurement, set_point, tick_elapsed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // drive_code
  output logic [1:0]  m_axis_tuser,   // updated, bad_set_point
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  pcfd_state_e state_q, state_d;

  // configuration registers
  logic signed [QW-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [15:0]          filter_time_q;
  logic [9:0]           sample_period_q;
  logic signed [18:0]   integ_upper_q, integ_lower_q, out_upper_q;

  // controller state
  logic signed [QW-1:0] integ_sum_q, deriv_filt_q, last_error_q, last_norm_q, ctrl_out_q;

  // per-item working registers
  logic [15:0]          meas_q, sp_q;
  logic                 gate_q, upd_q, bad_q;
  logic signed [QW-1:0] err_q, norm_q, p_q;
  logic signed [49:0]   dprod_q;
  logic [DIV_N_W-1:0]   fnum;
  logic                 fneg_q;

  // output register
  logic       out_valid_q;
  logic [7:0] out_code_q;
  logic       out_upd_q, out_bad_q;

  // serial units
  logic                      mul_start, mul_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_prod;
  logic                      div_start, div_done;
  logic [DIV_N_W-1:0]        div_num, div_quo;
  logic [DIV_D_W-1:0]        div_den;

  // datapath terms
  logic                 accept, out_free;
  logic signed [33:0]   ratio_diff;
  logic signed [24:0]   err_sum, norm_diff;
  logic signed [17:0]   tau_minus_ts;
  logic [DIV_D_W-1:0]   filt_den;
  logic signed [63:0]   integ_next, acc_f, nacc_shift, out_sum;
  logic signed [44:0]   fquo_signed;
  logic signed [32:0]   drive_prod;
  logic signed [16:0]   drive_shift;
  logic signed [17:0]   drive_val;
  logic [7:0]           drive_code;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     <= '0;
      integ_gain_q    <= '0;
      deriv_gain_q    <= '0;
      filter_time_q   <= '0;
      sample_period_q <= 10'd10;
      integ_upper_q   <= 19'sd65536;
      integ_lower_q   <= '0;
      out_upper_q     <= 19'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PROP_GAIN:     prop_gain_q     <= cfg_data_i;
        REG_INTEG_GAIN:    integ_gain_q    <= cfg_data_i;
        REG_DERIV_GAIN:    deriv_gain_q    <= cfg_data_i;
        REG_FILTER_TIME:   filter_time_q   <= cfg_data_i[15:0];
        REG_SAMPLE_PERIOD: sample_period_q <= cfg_data_i[9:0];
        REG_INTEG_UPPER:   integ_upper_q   <= cfg_data_i[18:0];
        REG_INTEG_LOWER:   integ_lower_q   <= cfg_data_i[18:0];
        REG_OUT_UPPER:     out_upper_q     <= cfg_data_i[18:0];
        default: ;
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept) state_d = ST_CHECK;
      ST_CHECK:    state_d = (gate_q && sp_q != 16'd0) ? ST_DIV_ERR : ST_EMIT;
      ST_DIV_ERR:  if (div_done) state_d = ST_DIV_NORM;
      ST_DIV_NORM: if (div_done) state_d = ST_MUL_P;
      ST_MUL_P:    if (mul_done) state_d = ST_MUL_I1;
      ST_MUL_I1:   if (mul_done) state_d = ST_MUL_I2;
      ST_MUL_I2:   if (mul_done) state_d = ST_MUL_D;
      ST_MUL_D:    if (mul_done) state_d = ST_MUL_F;
      ST_MUL_F:    if (mul_done) state_d = ST_PREP_F;
      ST_PREP_F:   state_d = (filt_den == '0) ? ST_FINISH : ST_DIV_F;
      ST_DIV_F:    if (div_done) state_d = ST_FINISH;
      ST_FINISH:   state_d = ST_EMIT;
      ST_EMIT:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // sequencer: outputs, a unit starts on entry to its step
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mul_start     = 1'b0;
    div_start     = 1'b0;
    if (state_d != state_q) begin
      case (state_d)
        ST_MUL_P, ST_MUL_I1, ST_MUL_I2, ST_MUL_D, ST_MUL_F: mul_start = 1'b1;
        ST_DIV_ERR, ST_DIV_NORM, ST_DIV_F:                  div_start = 1'b1;
        default: ;
      endcase
    end
  end

  // operand selection follows the step being entered
  assign err_sum      = 25'(err_q) + 25'(last_error_q);
  assign norm_diff    = 25'(norm_q) - 25'(last_norm_q);
  assign tau_minus_ts = $signed({1'b0, filter_time_q, 1'b0}) - $signed({8'b0, sample_period_q});
  assign filt_den     = {1'b0, filter_time_q, 1'b0} + {8'b0, sample_period_q};

  always_comb begin
    mul_a = MUL_A_W'(err_q);
    mul_b = MUL_B_W'(prop_gain_q);
    case (state_d)
      ST_MUL_I1: begin
        mul_a = MUL_A_W'(integ_gain_q);
        mul_b = err_sum;
      end
      ST_MUL_I2: begin
        mul_a = mul_prod[MUL_A_W-1:0];
        mul_b = {15'b0, sample_period_q};
      end
      ST_MUL_D: begin
        mul_a = MUL_A_W'(deriv_gain_q);
        mul_b = norm_diff;
      end
      ST_MUL_F: begin
        mul_a = MUL_A_W'(deriv_filt_q);
        mul_b = MUL_B_W'(tau_minus_ts);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_num = {12'b0, meas_q, 16'b0};
    div_den = {2'b0, sp_q};
    case (state_d)
      ST_DIV_NORM: div_den = {2'b0, MEAS_FULL_SCALE};
      ST_DIV_F: begin
        div_num = fnum;
        div_den = filt_den;
      end
      default: ;
    endcase
  end

  pcfd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  pcfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // error is one minus measurement over set point
  assign ratio_diff = 34'sd65536 - $signed({2'b00, div_quo[31:0]});

  // trapezoidal integrator step, clamped
  assign integ_next = clamp2(64'(integ_sum_q) + 64'(mul_prod >>> 17),
                             64'(integ_upper_q), 64'(integ_lower_q));

  // filter numerator, negated and floored by 2^16 so the divisor is just 2tau + Ts
  assign acc_f      = 64'(dprod_q) + (64'(mul_prod) <<< 16);
  assign nacc_shift = (-acc_f) >>> 16;
  assign fnum       = nacc_shift[63] ? ~nacc_shift[DIV_N_W-1:0] : nacc_shift[DIV_N_W-1:0];

  // floor division of a negative value through its complement
  assign fquo_signed = fneg_q ? $signed(~{1'b0, div_quo}) : $signed({1'b0, div_quo});

  assign out_sum = clamp2(64'(p_q) + 64'(integ_sum_q) + 64'(deriv_filt_q),
                          64'(out_upper_q), 64'(OUT_FLOOR));

  // drive code from the held controller output
  assign drive_prod  = $signed(ctrl_out_q) * $signed({1'b0, OUT_SCALE});
  assign drive_shift = 17'(drive_prod >>> 16);
  assign drive_val   = 18'(drive_shift) + $signed({10'b0, OUT_OFFSET});
  assign drive_code  = (drive_val < 18'sd0)   ? 8'd0 :
                       (drive_val > 18'sd255) ? 8'd255 : drive_val[7:0];

  // per-item working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q <= s_axis_tdata[15:0];
      sp_q   <= s_axis_tdata[31:16];
      gate_q <= (s_axis_tdata[47:32] > {6'b0, sample_period_q});
    end
    if (state_q == ST_CHECK) begin
      upd_q <= gate_q && (sp_q != 16'd0);
      bad_q <= gate_q && (sp_q == 16'd0);
    end
    if (state_q == ST_DIV_ERR && div_done) err_q <= sat24(64'(ratio_diff));
    if (state_q == ST_DIV_NORM && div_done) begin
      norm_q <= (div_quo > DIV_N_W'(Q_MAX)) ? Q_MAX : div_quo[QW-1:0];
    end
    if (state_q == ST_MUL_P && mul_done) p_q <= sat24(64'(mul_prod >>> 16));
    if (state_q == ST_MUL_D && mul_done) dprod_q <= {mul_prod[48:0], 1'b0};
    if (state_q == ST_PREP_F) fneg_q <= nacc_shift[63];
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_sum_q  <= '0;
      deriv_filt_q <= '0;
      last_error_q <= '0;
      last_norm_q  <= '0;
      ctrl_out_q   <= '0;
    end else begin
      if (state_q == ST_MUL_I2 && mul_done) integ_sum_q <= sat24(integ_next);
      if (state_q == ST_PREP_F && filt_den == '0) deriv_filt_q <= '0;
      if (state_q == ST_DIV_F && div_done) deriv_filt_q <= sat24(64'(fquo_signed));
      if (state_q == ST_FINISH) begin
        ctrl_out_q   <= sat24(out_sum);
        last_error_q <= err_q;
        last_norm_q  <= norm_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_code_q <= drive_code;
      out_upd_q  <= upd_q;
      out_bad_q  <= bad_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_code_q;
  assign m_axis_tuser  = {out_bad_q, out_upd_q};

endmodule

/* bench/tb_pid_controller_filtered_derivative.sv */
`timescale 1ns / 1ps

module tb_pid_controller_filtered_derivative import pcfd_pkg::*; ();

  localparam int    CLK_HALF     = 5;
  localparam int    RAND_PHASES  = 10;
  localparam int    PHASE_ITEMS  = 165;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int    HOLD_AT      = 300;   // transfer count at which the receiver holds off
  localparam int    HOLD_CYCLES  = 3000;
  localparam longint QMAX = 8388607;
  localparam longint QMIN = -8388608;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // measurement, set_point, tick_elapsed
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // drive_code
  logic [1:0]  m_axis_tuser;        // updated, bad_set_point
  logic        cfg_we_i = 1'b0;
  cfg_reg_e    cfg_idx_i = REG_PROP_GAIN;
  logic [23:0] cfg_data_i = '0;

  pid_controller_filtered_derivative DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #CLK_HALF clk_i = ~clk_i;

  typedef struct packed {
    logic [7:0] code;
    logic       upd;
    logic       bad;
  } drive_res_t;

  typedef struct {
    logic [15:0] meas;
    logic [15:0] sp;
    logic [15:0] tick;
    bit          typed;   // expectation written in the row
    drive_res_t  res;
  } stim_row_t;

  // shadow of the register file
  longint kp, ki, kd, tau, ts, i_hi, i_lo, o_hi;
  // shadow of the controller state
  longint integ_acc, deriv_acc, prev_err, prev_norm, ctrl_y;

  drive_res_t drive_q[$];
  int         mismatches = 0;
  int         n_taken = 0;
  longint     cycles = 0;
  bit         no_idle = 1'b0;

  function automatic longint clip_q(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  // upper bound first, then lower, so crossed limits behave as the block does
  function automatic longint limit(input longint v, input longint hi, input longint lo);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic drive_res_t controller_step(input logic [15:0] m, input logic [15:0] sp,
                                                 input logic [15:0] tk);
    drive_res_t r;
    longint err, norm, p, i, den, acc, n, q, d;
    r = '0;
    if (longint'(tk) > ts) begin
      if (sp == 0) begin
        r.bad = 1'b1;
      end else begin
        err  = clip_q(65536 - ((longint'(m) << 16) / longint'(sp)));
        norm = clip_q((longint'(m) << 16) / 65535);
        p    = clip_q((kp * err) >>> 16);
        i    = (ki * (err + prev_err) * ts) >>> 17;
        integ_acc = clip_q(limit(integ_acc + i, i_hi, i_lo));
        den = 2 * tau + ts;
        if (den == 0) begin
          deriv_acc = 0;
        end else begin
          acc = 2 * kd * (norm - prev_norm) + (2 * tau - ts) * deriv_acc * 65536;
          n = -acc;
          q = n / (den * 65536);
          if ((n % (den * 65536)) != 0 && n < 0) q--;
          deriv_acc = clip_q(q);
        end
        ctrl_y    = clip_q(limit(p + integ_acc + deriv_acc, o_hi, 0));
        prev_err  = err;
        prev_norm = norm;
        r.upd = 1'b1;
      end
    end
    d = (ctrl_y * 255) >>> 16;
    if (d < 0) d = 0;
    if (d > 255) d = 255;
    r.code = d[7:0];
    return r;
  endfunction

  // register writes back to back, write enable held across them
  task automatic write_regs(input longint vals[8]);
    for (int k = 0; k < 8; k++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_reg_e'(k);
      cfg_data_i <= vals[k][23:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    kp = vals[0]; ki = vals[1]; kd = vals[2]; tau = vals[3];
    ts = vals[4]; i_hi = vals[5]; i_lo = vals[6]; o_hi = vals[7];
  endtask

  // offer one item; returns just after the posedge that took it
  task automatic send_item(input logic [15:0] m, input logic [15:0] sp, input logic [15:0] tk,
                           input bit typed, input drive_res_t res);
    int gap;
    drive_res_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tk, sp, m};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = controller_step(m, sp, tk);
    drive_q.push_back(typed ? res : pred);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (drive_q.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic longint rnd_signed(input int bits);
    longint v;
    v = longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) << (bits - 1));
    return v;
  endfunction

  // random item, mostly near the gate threshold and with the measurement near the set point
  task automatic send_random();
    logic [15:0] m, sp, tk;
    int sel;
    sel = $urandom_range(0, 19);
    sp  = (sel == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    if (sel < 12) m = 16'(longint'(sp) + rnd_signed(12));
    else m = 16'($urandom());
    if (sel < 15) tk = 16'($urandom_range(ts > 3 ? ts - 3 : 0, ts + 40));
    else tk = 16'($urandom());
    send_item(m, sp, tk, 1'b0, '0);
  endtask

  // receiver: random hold-offs, and one long one to back the block up
  initial begin
    int w;
    drive_res_t want;
    wait (rst_ni);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 15);
      if (n_taken == HOLD_AT) w = HOLD_CYCLES;
      @(negedge clk_i);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      n_taken++;
      if (drive_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer code %0d user %b", $time, m_axis_tdata,
                 m_axis_tuser);
      end else begin
        want = drive_q.pop_front();
        if (m_axis_tdata !== want.code) begin
          mismatches++;
          $display("%0t: drive_code expected %0d actual %0d", $time, want.code, m_axis_tdata);
        end
        if (m_axis_tuser[0] !== want.upd) begin
          mismatches++;
          $display("%0t: updated expected %0b actual %0b", $time, want.upd, m_axis_tuser[0]);
        end
        if (m_axis_tuser[1] !== want.bad) begin
          mismatches++;
          $display("%0t: bad_set_point expected %0b actual %0b", $time, want.bad,
                   m_axis_tuser[1]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    longint vals[8];
    // defaults after reset: all gains zero, so every code is zero
    rows = '{
      '{16'd0,     16'd1,     16'd0,     1'b1, '{8'd0, 1'b0, 1'b0}},  // gate closed
      '{16'd5,     16'd7,     16'd10,    1'b1, '{8'd0, 1'b0, 1'b0}},  // tick equal to period
      '{16'd100,   16'd0,     16'd11,    1'b1, '{8'd0, 1'b0, 1'b1}},  // zero set point
      '{16'hFFFF,  16'd0,     16'hFFFF,  1'b1, '{8'd0, 1'b0, 1'b1}},
      '{16'd0,     16'd0,     16'd3,     1'b1, '{8'd0, 1'b0, 1'b0}},  // zero set point, gate shut
      '{16'hFFFF,  16'd1,     16'd11,    1'b1, '{8'd0, 1'b1, 1'b0}},  // error quotient saturates
      '{16'd0,     16'hFFFF,  16'hFFFF,  1'b1, '{8'd0, 1'b1, 1'b0}},
      '{16'hFFFF,  16'hFFFF,  16'd12,    1'b1, '{8'd0, 1'b1, 1'b0}},
      '{16'hAAAA,  16'h5555,  16'h5555,  1'b0, '0},
      '{16'h5555,  16'hAAAA,  16'hAAAA,  1'b0, '0}
    };
    vals = '{0, 0, 0, 0, 10, 65536, 0, 65536};
    kp = 0; ki = 0; kd = 0; tau = 0; ts = 10; i_hi = 65536; i_lo = 0; o_hi = 65536;
    integ_acc = 0; deriv_acc = 0; prev_err = 0; prev_norm = 0; ctrl_y = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[k]) send_item(rows[k].meas, rows[k].sp, rows[k].tick, rows[k].typed,
                                rows[k].res);
    drain();

    // moderate gains so the directed extremes below move the code
    write_regs('{65536, 4096, 65536, 5, 4, 65536, -65536, 131072});
    send_item(16'd0, 16'd1000, 16'd5, 1'b0, '0);
    send_item(16'd2000, 16'd1000, 16'd5, 1'b0, '0);
    send_item(16'hFFFF, 16'd1, 16'hFFFF, 1'b0, '0);
    send_item(16'd1, 16'hFFFF, 16'd7, 1'b0, '0);
    send_item(16'd500, 16'd1000, 16'd4, 1'b0, '0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: vals = '{8388607, 8388607, 8388607, 65535, 1000, 131072, -131072, 131072};
        1: vals = '{-8388608, -8388608, -8388608, 0, 1, -131072, -131072, -131072};
        2: vals = '{98304, 2000, 200000, 0, 0, 131072, -131072, 131072};  // zero denominator
        3: vals = '{65536, 3000, -100000, 20, 5, -20000, 40000, 131072};  // crossed limits
        default: begin
          vals[0] = rnd_signed(19);
          vals[1] = rnd_signed(14);
          vals[2] = rnd_signed(20);
          vals[3] = $urandom_range(0, 40);
          vals[4] = $urandom_range(1, 50);
          vals[5] = rnd_signed(18);
          vals[6] = vals[5] - $urandom_range(0, 70000);
          vals[7] = $urandom_range(0, 131072);
        end
      endcase
      if (ph >= 8) vals[4] = $urandom_range(0, 1023);
      no_idle = (ph % 3 == 2);
      write_regs(vals);
      repeat (PHASE_ITEMS) send_random();
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
